// ----- sv/edmg_pkg.sv -----
// Shared types and constants for the echo distance median gate.
// No dependencies; every other file of the block imports this package.
package edmg_pkg;

  // Field widths
  localparam int ECHO_W = 15;
  localparam int DIST_W = 19;
  localparam int PROD_W = 20;   // echo_time * 17 before range check
  localparam int STAT_W = 2;

  // Configuration port
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  // Defaults for the top-level parameters
  localparam int HISTORY_DEPTH_DEF = 5;
  localparam int SENSOR_COUNT_DEF  = 2;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef logic [STAT_W-1:0] status_t;

  // Result status codes
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_TIMEOUT  = 2'd1;
  localparam status_t ST_RANGE    = 2'd2;
  localparam status_t ST_UNSTABLE = 2'd3;

  // Register indexes
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_MIN_RANGE    = 2'd0;
  localparam reg_idx_t REG_MAX_RANGE    = 2'd1;
  localparam reg_idx_t REG_SPREAD_LIMIT = 2'd2;
  localparam reg_idx_t REG_WARN_LEVEL   = 2'd3;

  // Register reset values
  localparam logic [DIST_W-1:0] MIN_RANGE_RST    = 19'd2000;
  localparam logic [DIST_W-1:0] MAX_RANGE_RST    = 19'd425000;
  localparam logic [DIST_W-1:0] SPREAD_LIMIT_RST = 19'd10000;
  localparam logic [DIST_W-1:0] WARN_LEVEL_RST   = 19'd7000;

  // Classification that travels with each queued item
  typedef struct packed {
    logic    sensor;
    status_t status;   // ST_OK here means "ring written, gate pending"
  } edmg_tag_t;

endpackage

// ----- sv/edmg_if.sv -----
// Valid/ready channel interfaces for the echo and result streams.
// Depends on edmg_pkg for field widths and the status type.
interface edmg_in_if;
  import edmg_pkg::*;
  logic              valid;
  logic              ready;
  logic              sensor;
  logic [ECHO_W-1:0] echo_time;

  modport source (output valid, output sensor, output echo_time, input ready);
  modport sink   (input valid, input sensor, input echo_time, output ready);
endinterface

interface edmg_out_if;
  import edmg_pkg::*;
  logic              valid;
  logic              ready;
  logic              sensor_out;
  status_t           status;
  logic [DIST_W-1:0] filtered;
  logic              warning;

  modport source (output valid, output sensor_out, output status, output filtered,
                  output warning, input ready);
  modport sink   (input valid, input sensor_out, input status, input filtered,
                  input warning, output ready);
endinterface

// ----- sv/echo_distance_median_gate.sv -----
// Echo distance median gate: each echo time on echo_in gives one result on
// result_out. Distance is echo_time * 17 in 0.001 cm; an in-window distance
// goes into its sensor's ring, and the ring median is passed when the
// ring's max minus min is within spread_limit, else status is unstable.
// Channels: echo_in (sensor, echo_time) and result_out (sensor_out, status,
// filtered, warning), valid/ready, a transfer when both are high.
// Each result is held in the queue and then in the result register before it
// is offered on result_out.
// Throughput: one echo per cycle while the queue has room; ranking, median and
// gate are combinational between the queue and the result register.
// Stall: a two-entry queue and the result register absorb up to three
// results while result_out.ready is low; echo_in.ready then drops.
// Reset (rst, synchronous): rings cleared to zero, write slots to zero,
// registers to their defaults; no clearing pass, echoes taken at once.
// Registers over APB, one per word: min_range, max_range, spread_limit,
// warn_level; write them only while no echo is in flight.
// Depends on edmg_pkg, edmg_if, edmg_front, edmg_queue and edmg_back.
module echo_distance_median_gate #(
  parameter int HISTORY_DEPTH = edmg_pkg::HISTORY_DEPTH_DEF,
  parameter int SENSOR_COUNT  = edmg_pkg::SENSOR_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  edmg_in_if.sink                     echo_in,
  edmg_out_if.source                  result_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [edmg_pkg::APB_AW-1:0] paddr,
  input  logic [edmg_pkg::APB_DW-1:0] pwdata,
  output logic [edmg_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import edmg_pkg::*;

  localparam int ENTRY_W = $bits(edmg_tag_t) + HISTORY_DEPTH * DIST_W;

  logic [DIST_W-1:0] min_range;
  logic [DIST_W-1:0] max_range;
  logic [DIST_W-1:0] spread_limit;
  logic [DIST_W-1:0] warn_level;
  reg_idx_t          reg_idx;
  logic              cfg_wr;

  logic                                 push;
  logic                                 pop;
  logic                                 q_full;
  logic                                 q_empty;
  edmg_tag_t                            push_tag;
  edmg_tag_t                            q_tag;
  logic [HISTORY_DEPTH-1:0][DIST_W-1:0] push_ring;
  logic [HISTORY_DEPTH-1:0][DIST_W-1:0] q_ring;
  logic [ENTRY_W-1:0]                   push_data;
  logic [ENTRY_W-1:0]                   pop_data;

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_range    <= MIN_RANGE_RST;
      max_range    <= MAX_RANGE_RST;
      spread_limit <= SPREAD_LIMIT_RST;
      warn_level   <= WARN_LEVEL_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_MIN_RANGE:    min_range    <= pwdata[DIST_W-1:0];
        REG_MAX_RANGE:    max_range    <= pwdata[DIST_W-1:0];
        REG_SPREAD_LIMIT: spread_limit <= pwdata[DIST_W-1:0];
        REG_WARN_LEVEL:   warn_level   <= pwdata[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    case (reg_idx)
      REG_MIN_RANGE:    prdata = APB_DW'(min_range);
      REG_MAX_RANGE:    prdata = APB_DW'(max_range);
      REG_SPREAD_LIMIT: prdata = APB_DW'(spread_limit);
      REG_WARN_LEVEL:   prdata = APB_DW'(warn_level);
      default:          prdata = '0;
    endcase
  end

  edmg_front #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .SENSOR_COUNT  (SENSOR_COUNT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .echo_in   (echo_in),
    .min_range (min_range),
    .max_range (max_range),
    .q_full    (q_full),
    .push      (push),
    .push_tag  (push_tag),
    .push_ring (push_ring)
  );

  // Queue entry: tag above the ring snapshot
  assign push_data = {push_tag, push_ring};
  assign q_tag     = pop_data[ENTRY_W-1 -: $bits(edmg_tag_t)];
  assign q_ring    = pop_data[HISTORY_DEPTH*DIST_W-1:0];

  edmg_queue #(
    .W (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  edmg_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_tag        (q_tag),
    .q_ring       (q_ring),
    .spread_limit (spread_limit),
    .warn_level   (warn_level),
    .pop          (pop),
    .result_out   (result_out)
  );

endmodule

// ----- sv/edmg_front.sv -----
// Front end: accepts echoes, converts to distance, classifies and updates
// the per-sensor history rings. Depends on edmg_pkg and edmg_in_if.
module edmg_front #(
  parameter int HISTORY_DEPTH = edmg_pkg::HISTORY_DEPTH_DEF,
  parameter int SENSOR_COUNT  = edmg_pkg::SENSOR_COUNT_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  edmg_in_if.sink                                       echo_in,
  input  logic [edmg_pkg::DIST_W-1:0]                   min_range,
  input  logic [edmg_pkg::DIST_W-1:0]                   max_range,
  input  logic                                          q_full,
  output logic                                          push,
  output edmg_pkg::edmg_tag_t                           push_tag,
  output logic [HISTORY_DEPTH-1:0][edmg_pkg::DIST_W-1:0] push_ring
);
  import edmg_pkg::*;

  localparam int SIDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int SLOT_W = $clog2(HISTORY_DEPTH);

  logic [HISTORY_DEPTH-1:0][DIST_W-1:0] history [SENSOR_COUNT];
  logic [SLOT_W-1:0]                    write_slot [SENSOR_COUNT];

  logic [PROD_W-1:0] distance;
  logic [SIDX_W-1:0] sidx;
  logic [SLOT_W-1:0] slot;
  logic              sensor_ok;
  logic              timeout;
  logic              in_window;
  logic              store;

  // Distance = echo * 17 as shift and add, exact in 20 bits
  assign distance = (PROD_W'(echo_in.echo_time) << 4) + PROD_W'(echo_in.echo_time);

  assign sidx      = SIDX_W'(echo_in.sensor);
  assign sensor_ok = {31'd0, echo_in.sensor} < 32'(SENSOR_COUNT);
  assign timeout   = (echo_in.echo_time == '0);
  assign in_window = sensor_ok && (distance >= PROD_W'(min_range))
                     && (distance <= PROD_W'(max_range));
  assign slot      = write_slot[sidx];

  // Ready whenever the queue has room; a transfer happens when valid is also high
  assign echo_in.ready = ~q_full;
  assign push          = echo_in.valid & ~q_full;
  assign store         = push & ~timeout & in_window;

  // Classify; the spread gate is left to the back end
  always_comb begin
    push_tag.sensor = echo_in.sensor;
    if (timeout) begin
      push_tag.status = ST_TIMEOUT;
    end else if (!in_window) begin
      push_tag.status = ST_RANGE;
    end else begin
      push_tag.status = ST_OK;
    end
  end

  // Ring contents as they stand after this write
  always_comb begin
    for (int k = 0; k < HISTORY_DEPTH; k++) begin
      if (SLOT_W'(k) == slot) begin
        push_ring[k] = distance[DIST_W-1:0];
      end else begin
        push_ring[k] = history[sidx][k];
      end
    end
  end

  // History rings and write slots
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SENSOR_COUNT; s++) begin
        history[s]    <= '0;
        write_slot[s] <= '0;
      end
    end else if (store) begin
      history[sidx][slot] <= distance[DIST_W-1:0];
      if (slot == SLOT_W'(HISTORY_DEPTH - 1)) begin
        write_slot[sidx] <= '0;
      end else begin
        write_slot[sidx] <= slot + SLOT_W'(1);
      end
    end
  end

endmodule

// ----- sv/edmg_queue.sv -----
// Two-entry queue that decouples the front and back ends.
// Depends on edmg_pkg for the queue depth.
module edmg_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty
);
  import edmg_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]     entry [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entry[rd_ptr];

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ----- sv/edmg_back.sv -----
// Back end: ranks the ring, applies the spread gate, picks the median and
// holds the result register. Depends on edmg_pkg and edmg_out_if.
module edmg_back #(
  parameter int HISTORY_DEPTH = edmg_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           q_empty,
  input  edmg_pkg::edmg_tag_t                            q_tag,
  input  logic [HISTORY_DEPTH-1:0][edmg_pkg::DIST_W-1:0] q_ring,
  input  logic [edmg_pkg::DIST_W-1:0]                    spread_limit,
  input  logic [edmg_pkg::DIST_W-1:0]                    warn_level,
  output logic                                           pop,
  edmg_out_if.source                                     result_out
);
  import edmg_pkg::*;

  localparam int RANK_W  = $clog2(HISTORY_DEPTH);
  localparam int MED_IDX = HISTORY_DEPTH / 2;

  logic [RANK_W-1:0] rank [HISTORY_DEPTH];
  logic [DIST_W-1:0] med;
  logic [DIST_W-1:0] lo;
  logic [DIST_W-1:0] hi;
  logic              unstable;
  status_t           status_next;
  logic [DIST_W-1:0] filtered_next;
  logic              warning_next;

  logic              valid;
  logic              sensor_out;
  status_t           status;
  logic [DIST_W-1:0] filtered;
  logic              warning;

  // Rank of each entry; ties broken by position so ranks are a permutation
  always_comb begin
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      rank[i] = '0;
      for (int j = 0; j < HISTORY_DEPTH; j++) begin
        if ((q_ring[j] < q_ring[i]) || ((j < i) && (q_ring[j] == q_ring[i]))) begin
          rank[i] = rank[i] + RANK_W'(1);
        end
      end
    end
  end

  // Median, minimum and maximum picked out by rank
  always_comb begin
    med = '0;
    lo  = '0;
    hi  = '0;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      if (rank[i] == RANK_W'(MED_IDX)) begin
        med = q_ring[i];
      end
      if (rank[i] == '0) begin
        lo = q_ring[i];
      end
      if (rank[i] == RANK_W'(HISTORY_DEPTH - 1)) begin
        hi = q_ring[i];
      end
    end
  end

  assign unstable = (hi - lo) > spread_limit;

  // Spread gate and warning
  always_comb begin
    status_next   = q_tag.status;
    filtered_next = '0;
    warning_next  = 1'b0;
    if (q_tag.status == ST_OK) begin
      if (unstable) begin
        status_next = ST_UNSTABLE;
      end else begin
        filtered_next = med;
        warning_next  = (med != '0) && (med <= warn_level);
      end
    end
  end

  // Result register: loads when empty or being drained
  assign pop = ~q_empty & (~valid | result_out.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (~valid | result_out.ready) begin
      valid <= ~q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      sensor_out <= q_tag.sensor;
      status     <= status_next;
      filtered   <= filtered_next;
      warning    <= warning_next;
    end
  end

  assign result_out.valid      = valid;
  assign result_out.sensor_out = sensor_out;
  assign result_out.status     = status;
  assign result_out.filtered   = filtered;
  assign result_out.warning    = warning;

endmodule

// ----- sv/edmg_checker.sv -----
// Port-level checks on the echo distance median gate, bound to the top level.
// Depends on edmg_pkg and echo_distance_median_gate.
module edmg_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        sensor_out,
  input edmg_pkg::status_t           status,
  input logic [edmg_pkg::DIST_W-1:0] filtered,
  input logic                        warning
);
  import edmg_pkg::*;

  // Nothing is offered in the cycle after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered straight after reset");

  // A stalled result holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sensor_out) && $stable(status)
      && $stable(filtered) && $stable(warning))
    else $error("stalled result changed");

  // Only an ok result carries a distance or a warning
  a_not_ok_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> (filtered == '0) && !warning)
    else $error("non-ok result carries distance or warning");

  // A warning never comes with a zero median
  a_warn_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && warning |-> (filtered != '0) && (status == ST_OK))
    else $error("warning raised on zero median");

endmodule

bind echo_distance_median_gate edmg_checker u_edmg_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (result_out.valid),
  .out_ready  (result_out.ready),
  .sensor_out (result_out.sensor_out),
  .status     (result_out.status),
  .filtered   (result_out.filtered),
  .warning    (result_out.warning)
);

// ----- verif/echo_distance_median_gate_test.sv -----
// Self-checking testbench for echo_distance_median_gate: random and directed echo
// streams under several register settings, checked against a local ring-and-median
// predictor. Depends on edmg_pkg, edmg_if and the block itself.
module echo_distance_median_gate_test;
  import edmg_pkg::*;

  localparam int RING_DEPTH = HISTORY_DEPTH_DEF;
  localparam int SENSORS    = SENSOR_COUNT_DEF;

  typedef struct {
    logic              sensor;
    status_t           status;
    logic [DIST_W-1:0] filtered;
    logic              warning;
  } echo_result_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  edmg_in_if  echo_in ();
  edmg_out_if result_out ();

  echo_distance_median_gate DUT (
    .clk        (clk),
    .rst        (rst),
    .echo_in    (echo_in),
    .result_out (result_out),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Predictor state: registers, rings and write slots
  logic [DIST_W-1:0] cfg_reg [4];
  logic [DIST_W-1:0] ring [SENSORS][RING_DEPTH];
  int                ring_slot [SENSORS];

  echo_result_t expected_results [$];
  echo_result_t head;
  int           errors;
  bit           steady;      // no idling on either side while set
  int           centre [SENSORS];

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Overall time limit
  initial begin
    #3000000;
    $display("status: fail");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= 40)
      $display("mismatch: %s got %0d want %0d at %0t", what, got, want, $time);
  endtask

  // Expected result of one echo; updates the rings when the distance is accepted
  function automatic echo_result_t predict_echo(logic s, logic [ECHO_W-1:0] t);
    echo_result_t      r;
    logic [PROD_W-1:0] distance;
    logic [DIST_W-1:0] lo;
    logic [DIST_W-1:0] hi;
    logic [DIST_W-1:0] sorted [RING_DEPTH];
    logic [DIST_W-1:0] tmp;
    int                i;
    int                j;
    r.sensor   = s;
    r.status   = ST_OK;
    r.filtered = '0;
    r.warning  = 1'b0;
    if (t == '0) begin
      r.status = ST_TIMEOUT;
      return r;
    end
    distance = PROD_W'(t) * PROD_W'(17);
    if (distance < PROD_W'(cfg_reg[REG_MIN_RANGE])
        || distance > PROD_W'(cfg_reg[REG_MAX_RANGE])) begin
      r.status = ST_RANGE;
      return r;
    end
    ring[s][ring_slot[s]] = distance[DIST_W-1:0];
    ring_slot[s] = (ring_slot[s] + 1) % RING_DEPTH;
    lo = ring[s][0];
    hi = ring[s][0];
    for (i = 0; i < RING_DEPTH; i++) begin
      sorted[i] = ring[s][i];
      if (ring[s][i] < lo) lo = ring[s][i];
      if (ring[s][i] > hi) hi = ring[s][i];
    end
    if (hi - lo > cfg_reg[REG_SPREAD_LIMIT]) begin
      r.status = ST_UNSTABLE;
      return r;
    end
    // bubble sort for the median
    for (i = 0; i < RING_DEPTH - 1; i++)
      for (j = 0; j < RING_DEPTH - 1 - i; j++)
        if (sorted[j] > sorted[j+1]) begin
          tmp         = sorted[j];
          sorted[j]   = sorted[j+1];
          sorted[j+1] = tmp;
        end
    r.filtered = sorted[RING_DEPTH/2];
    r.warning  = (r.filtered != '0) && (r.filtered <= cfg_reg[REG_WARN_LEVEL]);
    return r;
  endfunction

  // Result side: random back-pressure
  always @(negedge clk) begin
    result_out.ready <= steady || ($urandom_range(0, 99) >= 27);
  end

  // Result checker: each transfer against the oldest expectation
  always @(posedge clk) begin
    if (!rst && result_out.valid && result_out.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending, status", int'(result_out.status), 0);
      end else begin
        head = expected_results.pop_front();
        if (result_out.sensor_out !== head.sensor)
          report_mismatch("sensor_out", int'(result_out.sensor_out), int'(head.sensor));
        if (result_out.status !== head.status)
          report_mismatch("status", int'(result_out.status), int'(head.status));
        if (result_out.filtered !== head.filtered)
          report_mismatch("filtered", int'(result_out.filtered), int'(head.filtered));
        if (result_out.warning !== head.warning)
          report_mismatch("warning", int'(result_out.warning), int'(head.warning));
      end
    end
  end

  // One echo transfer, with a random gap in front of it
  task automatic send_echo(input logic s, input logic [ECHO_W-1:0] t);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 27) begin
      echo_in.valid = 1'b0;
      @(negedge clk);
    end
    echo_in.valid     = 1'b1;
    echo_in.sensor    = s;
    echo_in.echo_time = t;
    do @(posedge clk); while (!echo_in.ready);
    expected_results.push_back(predict_echo(s, t));
  endtask

  // Stop sending and let every pending result come out
  task automatic wait_drained();
    @(negedge clk);
    echo_in.valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic apb_access(input reg_idx_t idx, input logic wr,
                            input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {idx, 2'b00};
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (wr) cfg_reg[idx] = wdata[DIST_W-1:0];
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Write a register and read it back
  task automatic write_reg(input reg_idx_t idx, input int value);
    logic [APB_DW-1:0] rd;
    apb_access(idx, 1'b1, APB_DW'(value), rd);
    apb_access(idx, 1'b0, '0, rd);
    if (rd !== APB_DW'(value)) report_mismatch("register read-back", int'(rd), value);
  endtask

  task automatic set_window(input int lo, input int hi, input int spread, input int warn);
    wait_drained();
    write_reg(REG_MIN_RANGE, lo);
    write_reg(REG_MAX_RANGE, hi);
    write_reg(REG_SPREAD_LIMIT, spread);
    write_reg(REG_WARN_LEVEL, warn);
  endtask

  // New cluster centre inside the window, often near its low edge
  function automatic void pick_centre(int s);
    int lo;
    int hi;
    lo = (int'(cfg_reg[REG_MIN_RANGE]) + 16) / 17;
    if (lo < 1) lo = 1;
    hi = int'(cfg_reg[REG_MAX_RANGE]) / 17;
    if (hi < lo) hi = lo;
    if ($urandom_range(0, 1))
      centre[s] = $urandom_range(lo, hi);
    else
      centre[s] = $urandom_range(lo, (hi < lo + 300) ? hi : lo + 300);
  endfunction

  // Mostly clustered echoes so the rings settle; some timeouts and noise
  task automatic run_random(input int count, input int jitter);
    int  k;
    int  r;
    int  t;
    logic s;
    pick_centre(0);
    pick_centre(1);
    for (k = 0; k < count; k++) begin
      s = 1'($urandom_range(0, 1));
      r = $urandom_range(0, 99);
      if (r < 4) begin
        t = 0;
      end else if (r < 16) begin
        t = $urandom_range(0, 32767);
      end else begin
        if ($urandom_range(0, 19) == 0) pick_centre(int'(s));
        t = centre[s] + int'($urandom_range(0, jitter)) - jitter / 2;
        if (t < 1) t = 1;
        if (t > 32767) t = 32767;
      end
      send_echo(s, ECHO_W'(t));
    end
  endtask

  task automatic test_reset_values();
    logic [APB_DW-1:0] rd;
    apb_access(REG_MIN_RANGE, 1'b0, '0, rd);
    if (rd !== APB_DW'(MIN_RANGE_RST))
      report_mismatch("min_range reset", int'(rd), int'(MIN_RANGE_RST));
    apb_access(REG_MAX_RANGE, 1'b0, '0, rd);
    if (rd !== APB_DW'(MAX_RANGE_RST))
      report_mismatch("max_range reset", int'(rd), int'(MAX_RANGE_RST));
    apb_access(REG_SPREAD_LIMIT, 1'b0, '0, rd);
    if (rd !== APB_DW'(SPREAD_LIMIT_RST))
      report_mismatch("spread_limit reset", int'(rd), int'(SPREAD_LIMIT_RST));
    apb_access(REG_WARN_LEVEL, 1'b0, '0, rd);
    if (rd !== APB_DW'(WARN_LEVEL_RST))
      report_mismatch("warn_level reset", int'(rd), int'(WARN_LEVEL_RST));
  endtask

  // Timeout, below and above the window, cleared entries giving a zero median,
  // an unstable ring, and a warning that fades as the distance rises
  task automatic test_directed();
    int s0 [8] = '{0, 1, 117, 118, 25000, 25001, 32767, 16384};
    int s1 [8] = '{400, 400, 400, 411, 412, 412, 413, 0};
    int k;
    for (k = 0; k < 8; k++) send_echo(1'b0, ECHO_W'(s0[k]));
    for (k = 0; k < 8; k++) send_echo(1'b1, ECHO_W'(s1[k]));
  endtask

  task automatic test_defaults_random();
    run_random(225, 60);
    // hold off until every result is back, then carry on
    wait_drained();
    run_random(225, 60);
  endtask

  task automatic test_spread_zero();
    set_window(0, 425000, 0, 425000);
    run_random(200, 0);
  endtask

  // Window of a single distance; never warns
  task automatic test_single_distance();
    set_window(17000, 17000, 425000, 0);
    run_random(150, 2);
  endtask

  // Minimum above maximum: every echo is timeout or out of range
  task automatic test_inverted_window();
    set_window(425000, 0, 10000, 7000);
    run_random(100, 40);
  endtask

  // Exact window edges and a median exactly on the warning level
  task automatic test_window_edges();
    int s0 [4] = '{199, 200, 20000, 20001};
    int k;
    set_window(3400, 340000, 2000, 6800);
    for (k = 0; k < 4; k++) send_echo(1'b0, ECHO_W'(s0[k]));
    for (k = 0; k < 5; k++) send_echo(1'b1, ECHO_W'(400));
    run_random(250, 100);
  endtask

  task automatic test_steady_stream();
    set_window(int'(MIN_RANGE_RST), int'(MAX_RANGE_RST), int'(SPREAD_LIMIT_RST),
               int'(WARN_LEVEL_RST));
    steady = 1'b1;
    run_random(200, 60);
    steady = 1'b0;
  endtask

  // Main sequence
  initial begin
    int k;
    rst                  = 1'b1;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    echo_in.valid        = 1'b0;
    echo_in.sensor       = 1'b0;
    echo_in.echo_time    = '0;
    result_out.ready     = 1'b0;
    errors               = 0;
    steady               = 1'b0;
    cfg_reg[REG_MIN_RANGE]    = MIN_RANGE_RST;
    cfg_reg[REG_MAX_RANGE]    = MAX_RANGE_RST;
    cfg_reg[REG_SPREAD_LIMIT] = SPREAD_LIMIT_RST;
    cfg_reg[REG_WARN_LEVEL]   = WARN_LEVEL_RST;
    for (k = 0; k < SENSORS; k++) begin
      ring[k]      = '{default: '0};
      ring_slot[k] = 0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_values();
    test_directed();
    test_defaults_random();
    test_spread_zero();
    test_single_distance();
    test_inverted_window();
    test_window_edges();
    test_steady_stream();

    // Drain with a bound, then settle
    @(negedge clk);
    echo_in.valid = 1'b0;
    k = 0;
    while (expected_results.size() != 0 && k < 5000) begin
      @(posedge clk);
      k++;
    end
    repeat (6) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results never delivered", 0, expected_results.size());
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/edmg_pkg.sv
sv/edmg_if.sv
sv/edmg_front.sv
sv/edmg_queue.sv
sv/edmg_back.sv
sv/echo_distance_median_gate.sv
sv/edmg_checker.sv
verif/echo_distance_median_gate_test.sv
